>>> design/slpf_pkg.sv
package slpf_pkg;

	localparam int HOLD_COUNT_WIDTH = 16;
	localparam int CFG_W            = 16;
	localparam int HOLD_CMP_W       = (HOLD_COUNT_WIDTH > CFG_W) ? HOLD_COUNT_WIDTH : CFG_W;
	localparam logic [CFG_W-1:0] LONG_PRESS_RESET = CFG_W'(5);

	// event kinds
	localparam logic [4:0] K_HIGHLIGHT  = 5'd0;
	localparam logic [4:0] K_RECOVERY   = 5'd1;
	localparam logic [4:0] K_TEMP_WARN  = 5'd2;
	localparam logic [4:0] K_TEMP_SHUT  = 5'd3;
	localparam logic [4:0] K_POWER_SHUT = 5'd4;
	localparam logic [4:0] K_I2C_WARN   = 5'd5;
	localparam logic [4:0] K_I2C_SHUT   = 5'd6;
	localparam logic [4:0] K_CARD_WARN  = 5'd7;
	localparam logic [4:0] K_BOOT       = 5'd8;
	localparam logic [4:0] K_CLEAR      = 5'd9;
	localparam logic [4:0] K_GOT_JOB    = 5'd10;
	localparam logic [4:0] K_DISCONNECT = 5'd11;
	localparam logic [4:0] K_GOT_ACK    = 5'd12;
	localparam logic [4:0] K_STOP       = 5'd13;
	localparam logic [4:0] K_RESET      = 5'd14;
	localparam logic [4:0] K_BUTTON     = 5'd15;
	localparam logic [4:0] K_TICK       = 5'd16;

	localparam logic [1:0] COL_RED    = 2'd0;
	localparam logic [1:0] COL_YELLOW = 2'd1;
	localparam logic [1:0] COL_GREEN  = 2'd2;
	localparam logic [1:0] COL_BLUE   = 2'd3;

	localparam logic [1:0] HM_BACKGROUND = 2'd0;
	localparam logic [1:0] HM_HIGHLIGHT  = 2'd1;
	localparam logic [1:0] HM_RECOVERY   = 2'd2;
	localparam logic [1:0] HM_USER       = 2'd3;

	localparam logic [1:0] AM_NORMAL   = 2'd0;
	localparam logic [1:0] AM_WARN     = 2'd1;
	localparam logic [1:0] AM_ACKED    = 2'd2;
	localparam logic [1:0] AM_SHUTDOWN = 2'd3;

	localparam logic [6:0] FB_TEMP_WARN  = 7'h01;
	localparam logic [6:0] FB_TEMP_SHUT  = 7'h02;
	localparam logic [6:0] FB_POWER_SHUT = 7'h04;
	localparam logic [6:0] FB_I2C_SHUT   = 7'h08;
	localparam logic [6:0] FB_I2C_WARN   = 7'h10;
	localparam logic [6:0] FB_CARD_WARN  = 7'h20;
	localparam logic [6:0] FB_BOOT       = 7'h40;
	localparam logic [6:0] SHUT_SET = FB_TEMP_SHUT | FB_POWER_SHUT | FB_I2C_SHUT;
	localparam logic [6:0] WARN_SET = FB_TEMP_WARN | FB_CARD_WARN | FB_I2C_WARN | FB_BOOT;

	typedef struct packed {
		logic [1:0] led_color;
		logic       led_blink;
		logic       led_update;
		logic [3:0] clear_cmds;
		logic       publish_clear;
		logic       publish_highlight_off;
		logic       cancel_dark_mode;
		logic       long_press;
	} result_t;

	typedef struct packed {
		logic [1:0] mode;
		logic       refresh;
	} abn_eval_t;

	typedef struct packed {
		logic [1:0] color;
		logic       blink;
	} led_t;

	function automatic logic [6:0] fault_mask(input logic [4:0] kind);
		logic [6:0] m;
		m = '0;
		case (kind)
			K_TEMP_WARN:  m = FB_TEMP_WARN;
			K_TEMP_SHUT:  m = FB_TEMP_SHUT;
			K_POWER_SHUT: m = FB_POWER_SHUT;
			K_I2C_WARN:   m = FB_I2C_WARN;
			K_I2C_SHUT:   m = FB_I2C_SHUT;
			K_CARD_WARN:  m = FB_CARD_WARN;
			K_BOOT:       m = FB_BOOT;
			default:      m = '0;
		endcase
		return m;
	endfunction

	// abnormal mode after a change of the fault set; refresh even if mode is rewritten unchanged
	function automatic abn_eval_t eval_abnormal(input logic [1:0] mode, input logic [6:0] f);
		abn_eval_t r;
		r.mode    = mode;
		r.refresh = 1'b0;
		unique case (mode) inside
			AM_NORMAL: begin
				if (|(f & SHUT_SET)) begin
					r.mode    = AM_SHUTDOWN;
					r.refresh = 1'b1;
				end else if (|(f & WARN_SET)) begin
					r.mode    = AM_WARN;
					r.refresh = 1'b1;
				end
			end
			AM_WARN, AM_ACKED: begin
				if (f == '0) begin
					r.mode    = AM_NORMAL;
					r.refresh = 1'b1;
				end
				if (|(f & SHUT_SET)) begin
					r.mode    = AM_SHUTDOWN;
					r.refresh = 1'b1;
				end
			end
			default: begin
				if (f == '0) begin
					r.mode    = AM_NORMAL;
					r.refresh = 1'b1;
				end
				if (|(f & WARN_SET) && ((f & ~WARN_SET) == '0)) begin
					r.mode    = AM_WARN;
					r.refresh = 1'b1;
				end
			end
		endcase
		return r;
	endfunction

	// layer priority: highlight, abnormal, pool/mining
	function automatic led_t show(input logic [1:0] hl, input logic [1:0] ab,
		input logic pool, input logic mine);
		led_t l;
		l.blink = 1'b0;
		if (hl == HM_HIGHLIGHT) begin
			l.color = COL_BLUE;
			l.blink = 1'b1;
		end else if (hl != HM_BACKGROUND) begin
			l.color = COL_BLUE;
		end else if (ab == AM_WARN) begin
			l.color = COL_YELLOW;
			l.blink = 1'b1;
		end else if (ab == AM_SHUTDOWN) begin
			l.color = COL_RED;
			l.blink = 1'b1;
		end else if (!pool || !mine) begin
			l.color = COL_YELLOW;
		end else begin
			l.color = COL_GREEN;
		end
		return l;
	endfunction

endpackage

>>> design/slpf_in_if.sv
interface slpf_in_if;
	logic       valid;
	logic       ready;
	logic [4:0] kind;
	logic       level;

	modport source(output valid, output kind, output level, input ready);
	modport sink(input valid, input kind, input level, output ready);
endinterface

>>> design/slpf_out_if.sv
interface slpf_out_if;
	logic       valid;
	logic       ready;
	logic [1:0] led_color;
	logic       led_blink;
	logic       led_update;
	logic [3:0] clear_cmds;
	logic       publish_clear;
	logic       publish_highlight_off;
	logic       cancel_dark_mode;
	logic       long_press;

	modport source(output valid, output led_color, output led_blink, output led_update,
		output clear_cmds, output publish_clear, output publish_highlight_off,
		output cancel_dark_mode, output long_press, input ready);
	modport sink(input valid, input led_color, input led_blink, input led_update,
		input clear_cmds, input publish_clear, input publish_highlight_off,
		input cancel_dark_mode, input long_press, output ready);
endinterface

>>> design/status_led_priority_fsm_unit.sv
// Status LED priority unit. Takes one event beat per cycle on event_ch and returns exactly
// one result beat per event on status_ch, in order, through two registers: the event
// is captured in an input register, then the highlight, abnormal, pool and mining state
// machines, fault set, button state and hold counter are updated in one pass while the
// result (LED color/blink by layer priority plus request pulses) is loaded into the
// output register. Sustained rate is one event per cycle; status_ch backpressure stalls
// the two-register pipeline. cfg_we/cfg_data write the long-press threshold (ticks,
// reset 5); write it only while no event is in flight.
module status_led_priority_fsm_unit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [slpf_pkg::CFG_W-1:0] cfg_data,
	slpf_in_if.sink                    event_ch,
	slpf_out_if.source                 status_ch
);

	logic                       valid_s1;
	logic [4:0]                 kind_s1;
	logic                       level_s1;
	logic                       valid_s2;
	slpf_pkg::result_t          res_s2;
	slpf_pkg::result_t          res;
	logic [slpf_pkg::CFG_W-1:0] lp_ticks_q;
	logic                       adv;
	logic                       in_take;

	assign adv            = !valid_s2 || status_ch.ready;
	assign event_ch.ready = !valid_s1 || adv;
	assign in_take        = event_ch.valid && event_ch.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lp_ticks_q <= slpf_pkg::LONG_PRESS_RESET;
		end else if (cfg_we) begin
			lp_ticks_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (in_take) begin
				valid_s1 <= 1'b1;
			end else if (adv) begin
				valid_s1 <= 1'b0;
			end
			if (adv) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			kind_s1  <= event_ch.kind;
			level_s1 <= event_ch.level;
		end
		if (valid_s1 && adv) begin
			res_s2 <= res;
		end
	end

	slpf_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.ev_valid (valid_s1 && adv),
		.kind     (kind_s1),
		.level    (level_s1),
		.lp_ticks (lp_ticks_q),
		.res      (res)
	);

	assign status_ch.valid                 = valid_s2;
	assign status_ch.led_color             = res_s2.led_color;
	assign status_ch.led_blink             = res_s2.led_blink;
	assign status_ch.led_update            = res_s2.led_update;
	assign status_ch.clear_cmds            = res_s2.clear_cmds;
	assign status_ch.publish_clear         = res_s2.publish_clear;
	assign status_ch.publish_highlight_off = res_s2.publish_highlight_off;
	assign status_ch.cancel_dark_mode      = res_s2.cancel_dark_mode;
	assign status_ch.long_press            = res_s2.long_press;

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1 && $stable(kind_s1) && $stable(level_s1))
		else $error("stalled event lost from input stage");

	a_s1_moves_to_s2: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv |=> valid_s2)
		else $error("event dropped between stages");

	a_no_take_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !status_ch.ready |-> !event_ch.ready)
		else $error("input accepted while pipeline full");

endmodule

>>> design/slpf_core.sv
module slpf_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         ev_valid,
	input  logic [4:0]                   kind,
	input  logic                         level,
	input  logic [slpf_pkg::CFG_W-1:0]   lp_ticks,
	output slpf_pkg::result_t            res
);

	logic [1:0] hl_q, hl_n;
	logic [1:0] ab_q, ab_n;
	logic [6:0] fault_q, fault_n;
	logic       pool_q, pool_n;
	logic       mine_q, mine_n;
	logic       held_q, held_n;
	logic [slpf_pkg::HOLD_COUNT_WIDTH-1:0] hold_q, hold_n, hold_inc;
	logic       fired_q, fired_n;

	slpf_pkg::abn_eval_t ev;
	slpf_pkg::led_t      led;
	logic [6:0]          fmask;
	logic                refresh;
	logic [3:0]          clears;
	logic                pub_clear, pub_hl_off, dark, lp;

	assign hold_inc = (hold_q != '1) ? hold_q + 1'b1 : hold_q;

	always_comb begin
		hl_n       = hl_q;
		ab_n       = ab_q;
		fault_n    = fault_q;
		pool_n     = pool_q;
		mine_n     = mine_q;
		held_n     = held_q;
		hold_n     = hold_q;
		fired_n    = fired_q;
		refresh    = 1'b0;
		clears     = '0;
		pub_clear  = 1'b0;
		pub_hl_off = 1'b0;
		dark       = 1'b0;
		lp         = 1'b0;
		fmask      = slpf_pkg::fault_mask(kind);
		ev         = slpf_pkg::eval_abnormal(ab_q, fault_q);
		unique case (kind) inside
			slpf_pkg::K_HIGHLIGHT: begin
				if (hl_q == slpf_pkg::HM_BACKGROUND || hl_q == slpf_pkg::HM_USER) begin
					if (level) begin
						hl_n    = slpf_pkg::HM_HIGHLIGHT;
						refresh = 1'b1;
					end
				end else if (hl_q == slpf_pkg::HM_HIGHLIGHT && !level) begin
					hl_n    = slpf_pkg::HM_BACKGROUND;
					refresh = 1'b1;
				end
			end
			slpf_pkg::K_RECOVERY: begin
				if (level) begin
					hl_n    = slpf_pkg::HM_RECOVERY;
					refresh = 1'b1;
				end
			end
			slpf_pkg::K_TEMP_WARN, slpf_pkg::K_TEMP_SHUT, slpf_pkg::K_POWER_SHUT,
			slpf_pkg::K_I2C_WARN, slpf_pkg::K_I2C_SHUT, slpf_pkg::K_CARD_WARN,
			slpf_pkg::K_BOOT: begin
				fault_n = level ? (fault_q | fmask) : (fault_q & ~fmask);
				ev      = slpf_pkg::eval_abnormal(ab_q, fault_n);
				ab_n    = ev.mode;
				refresh = ev.refresh;
			end
			slpf_pkg::K_CLEAR: begin
				// only the boot problem is cleared locally; card warn and the temp, power and I2C shutdowns go out as requests
				if (|(fault_q & slpf_pkg::FB_BOOT)) begin
					fault_n = fault_q & ~slpf_pkg::FB_BOOT;
					ev      = slpf_pkg::eval_abnormal(ab_q, fault_n);
					ab_n    = ev.mode;
					refresh = ev.refresh;
				end
				clears = {|(fault_q & slpf_pkg::FB_CARD_WARN),
					|(fault_q & slpf_pkg::FB_I2C_SHUT),
					|(fault_q & slpf_pkg::FB_POWER_SHUT),
					|(fault_q & slpf_pkg::FB_TEMP_SHUT)};
			end
			slpf_pkg::K_GOT_JOB: begin
				pool_n  = 1'b1;
				refresh = !pool_q;
			end
			slpf_pkg::K_DISCONNECT: begin
				pool_n  = 1'b0;
				refresh = pool_q;
			end
			slpf_pkg::K_GOT_ACK: begin
				mine_n  = 1'b1;
				refresh = !mine_q;
			end
			slpf_pkg::K_STOP: begin
				mine_n  = 1'b0;
				refresh = mine_q;
			end
			slpf_pkg::K_RESET: begin
				pool_n  = 1'b0;
				mine_n  = 1'b0;
				refresh = 1'b1;
			end
			slpf_pkg::K_BUTTON: begin
				if (level && !held_q) begin
					hold_n = '0;
				end
				held_n = level;
				if (level) begin
					dark      = 1'b1;
					pub_clear = 1'b1;
					if (ab_q == slpf_pkg::AM_WARN) begin
						ab_n = slpf_pkg::AM_ACKED;
					end
				end else begin
					fired_n = 1'b0;
				end
				if (hl_q == slpf_pkg::HM_HIGHLIGHT) begin
					pub_hl_off = 1'b1;
					hl_n       = slpf_pkg::HM_BACKGROUND;
				end else begin
					hl_n = level ? slpf_pkg::HM_USER : slpf_pkg::HM_BACKGROUND;
				end
				refresh = 1'b1;
			end
			slpf_pkg::K_TICK: begin
				if (held_q) begin
					hold_n = hold_inc;
					if (slpf_pkg::HOLD_CMP_W'(hold_inc) >= slpf_pkg::HOLD_CMP_W'(lp_ticks)
						&& !fired_q) begin
						fired_n = 1'b1;
						lp      = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		led = slpf_pkg::show(hl_n, ab_n, pool_n, mine_n);
		res.led_color             = led.color;
		res.led_blink             = led.blink;
		res.led_update            = refresh;
		res.clear_cmds            = clears;
		res.publish_clear         = pub_clear;
		res.publish_highlight_off = pub_hl_off;
		res.cancel_dark_mode      = dark;
		res.long_press            = lp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hl_q    <= slpf_pkg::HM_BACKGROUND;
			ab_q    <= slpf_pkg::AM_NORMAL;
			fault_q <= '0;
			pool_q  <= 1'b0;
			mine_q  <= 1'b0;
			held_q  <= 1'b0;
			hold_q  <= '0;
			fired_q <= 1'b0;
		end else if (ev_valid) begin
			hl_q    <= hl_n;
			ab_q    <= ab_n;
			fault_q <= fault_n;
			pool_q  <= pool_n;
			mine_q  <= mine_n;
			held_q  <= held_n;
			hold_q  <= hold_n;
			fired_q <= fired_n;
		end
	end

	a_lp_needs_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && res.long_press |-> kind == slpf_pkg::K_TICK && held_q && !fired_q)
		else $error("long press without an armed hold");

	a_lp_arms_fired: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && res.long_press |=> fired_q)
		else $error("long press did not latch fired");

	a_clears_only_on_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && res.clear_cmds != '0 |-> kind == slpf_pkg::K_CLEAR)
		else $error("clear request on a non-clear event");

	a_fault_set_shutdown: assert property (@(posedge clk) disable iff (!arst_n)
		ev_valid && fault_n == '0 && fault_q != '0 |=> ab_q == slpf_pkg::AM_NORMAL)
		else $error("abnormal mode stuck after faults cleared");

endmodule
